FILE: hw/rtl/ows_pkg.sv
package ows_pkg;

    // field widths fixed by the interface
    localparam int ROM_ID_W         = 64;
    localparam int INDEX_W          = 6;
    localparam int COUNT_W          = 8;
    localparam int ROM_BITS_DEFAULT = 64;

    localparam logic [COUNT_W-1:0] MAX_DEVICES_RESET = 8'h08;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'hff;

    // item kinds
    typedef enum logic [1:0] {
        MODE_RESTART = 2'd0,
        MODE_BEGIN   = 2'd1,
        MODE_PAIR    = 2'd2,
        MODE_IGNORE  = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_MORE     = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_ABORT    = 2'd3
    } status_t;

    typedef struct packed {
        mode_t mode;
        logic  id_bit;
        logic  complement_bit;
    } item_t;

    typedef struct packed {
        logic                 write_bit;
        logic [INDEX_W-1:0]   bit_index;
        status_t              status;
        logic [ROM_ID_W-1:0]  rom_id;
        logic [COUNT_W-1:0]   device_count;
    } result_t;

endpackage

FILE: hw/rtl/onewire_rom_search.sv
// An input transfer is captured in the input register, and its result then in the
// result register.
// One item per cycle while the result register is not stalled by out_ready.
// Reset clears the search state, the pipeline valids, and sets max_devices to 8.
// Results may wait at the output while the next item is already held at the input.
module onewire_rom_search
    import ows_pkg::*;
#(
    parameter int ROM_BITS = ROM_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic                id_bit,
    input  logic                complement_bit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                write_bit,
    output logic [INDEX_W-1:0]  bit_index,
    output logic [1:0]          status,
    output logic [ROM_ID_W-1:0] rom_id,
    output logic [COUNT_W-1:0]  device_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COUNT_W-1:0]  cfg_data
);

    logic               in_valid_reg;
    item_t              item_reg;
    logic               out_valid_reg;
    result_t            res_reg;
    result_t            res;
    logic               advance;
    logic [COUNT_W-1:0] max_devices_reg;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_devices_reg <= MAX_DEVICES_RESET;
        else if (cfg_valid && cfg_ready)
            max_devices_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.mode           <= mode_t'(mode);
            item_reg.id_bit         <= id_bit;
            item_reg.complement_bit <= complement_bit;
        end
    end

    ows_engine #(
        .ROM_BITS (ROM_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (item_reg),
        .max_devices (max_devices_reg),
        .res         (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= advance || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign write_bit    = res_reg.write_bit;
    assign bit_index    = res_reg.bit_index;
    assign status       = res_reg.status;
    assign rom_id       = res_reg.rom_id;
    assign device_count = res_reg.device_count;

endmodule

FILE: hw/rtl/ows_engine.sv
module ows_engine
    import ows_pkg::*;
#(
    parameter int ROM_BITS = ROM_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  item_t              item,
    input  logic [COUNT_W-1:0] max_devices,
    output result_t            res
);

    localparam int K_W   = $clog2(ROM_BITS + 1);
    localparam int POS_W = $clog2(ROM_BITS);

    logic [ROM_BITS-1:0] rom_reg, rom_next;
    logic [K_W-1:0]      last_branch_reg, last_branch_next;
    logic [K_W-1:0]      pass_branch_reg, pass_branch_next;
    logic [K_W-1:0]      bit_pos_reg, bit_pos_next;
    logic [COUNT_W-1:0]  found_reg, found_next;
    logic                done_reg, done_next;

    logic [POS_W-1:0]    pos;
    logic                sel;
    logic [COUNT_W-1:0]  limit;
    logic [COUNT_W-1:0]  found_inc;

    assign pos       = POS_W'(bit_pos_reg - K_W'(1));
    assign limit     = (max_devices != '0) ? max_devices : COUNT_W'(1);
    assign found_inc = (found_reg != COUNT_MAX) ? found_reg + COUNT_W'(1) : found_reg;

    // direction choice for a pair with no conflict
    always_comb
    begin
        priority if (item.id_bit)
            sel = 1'b1;
        else if (item.complement_bit)
            sel = 1'b0;
        else if (bit_pos_reg < last_branch_reg)
            sel = rom_reg[pos];
        else if (bit_pos_reg == last_branch_reg)
            sel = 1'b0;
        else
            sel = 1'b1;
    end

    // state update and result
    always_comb
    begin
        rom_next         = rom_reg;
        last_branch_next = last_branch_reg;
        pass_branch_next = pass_branch_reg;
        bit_pos_next     = bit_pos_reg;
        found_next       = found_reg;
        done_next        = done_reg;
        res.write_bit    = 1'b0;
        res.bit_index    = '0;
        res.status       = ST_CONTINUE;

        unique case (item.mode)
            MODE_RESTART:
            begin
                rom_next         = '0;
                last_branch_next = '0;
                pass_branch_next = '0;
                bit_pos_next     = K_W'(1);
                found_next       = '0;
                done_next        = 1'b0;
            end
            MODE_BEGIN:
            begin
                if (!done_reg)
                begin
                    pass_branch_next = '0;
                    bit_pos_next     = K_W'(1);
                end
            end
            MODE_PAIR:
            begin
                if (done_reg)
                begin
                    res.status = ST_ABORT;
                end
                else
                begin
                    res.bit_index = INDEX_W'(pos);
                    if (item.id_bit && item.complement_bit)
                    begin
                        // no device answered consistently
                        done_next        = 1'b1;
                        pass_branch_next = '0;
                        bit_pos_next     = K_W'(1);
                        res.status       = ST_ABORT;
                    end
                    else
                    begin
                        // a one taken at a collision marks a branch point
                        if (sel && !item.id_bit && !item.complement_bit)
                            pass_branch_next = bit_pos_reg;
                        rom_next[pos] = sel;
                        res.write_bit = sel;
                        if (bit_pos_reg >= K_W'(ROM_BITS))
                        begin
                            // last bit of the pass
                            found_next = found_inc;
                            if (pass_branch_next == '0 || found_inc >= limit)
                            begin
                                res.status = ST_COMPLETE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                res.status = ST_MORE;
                            end
                            last_branch_next = pass_branch_next;
                            pass_branch_next = '0;
                            bit_pos_next     = K_W'(1);
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg + K_W'(1);
                        end
                    end
                end
            end
            MODE_IGNORE:
            begin
            end
            default:
            begin
            end
        endcase

        res.rom_id       = ROM_ID_W'(rom_next);
        res.device_count = found_next;
    end

    // search state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg         <= '0;
            last_branch_reg <= '0;
            pass_branch_reg <= '0;
            bit_pos_reg     <= K_W'(1);
            found_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else if (advance)
        begin
            rom_reg         <= rom_next;
            last_branch_reg <= last_branch_next;
            pass_branch_reg <= pass_branch_next;
            bit_pos_reg     <= bit_pos_next;
            found_reg       <= found_next;
            done_reg        <= done_next;
        end
    end

endmodule

FILE: hw/rtl/ows_checker.sv
module ows_checker
    import ows_pkg::*;
#(
    parameter int ROM_BITS = ROM_BITS_DEFAULT
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic                write_bit,
    input logic [INDEX_W-1:0]  bit_index,
    input logic [1:0]          status,
    input logic [ROM_ID_W-1:0] rom_id,
    input logic [COUNT_W-1:0]  device_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rom_id) && $stable(status))
        else $error("result changed while stalled");

    // a found device is only reported on the last bit of a pass
    a_found_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_MORE || status == ST_COMPLETE)
            |-> bit_index == INDEX_W'(ROM_BITS - 1))
        else $error("device reported before last bit");

    // a found device always counts
    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_MORE || status == ST_COMPLETE) |-> device_count != '0)
        else $error("device found with zero count");

    // an abort never writes a one
    a_abort_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ABORT |-> !write_bit)
        else $error("abort with direction one");

endmodule

bind onewire_rom_search ows_checker #(
    .ROM_BITS (ROM_BITS)
) u_ows_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_bit    (write_bit),
    .bit_index    (bit_index),
    .status       (status),
    .rom_id       (rom_id),
    .device_count (device_count)
);
